// File: hdl/aphf_pkg.sv
// ============================================================================
// aphf_pkg: shared types, constants and firing-delay table
// Item and result words of the phase-angle firing block, timing constants
// and the table of rise delays that splits the half-wave area into equal steps.
// ============================================================================
package aphf_pkg;

    // Number of power levels and the top level that a request clamps to.
    localparam int LEVELS    = 128;
    localparam int TOP_LEVEL = ((LEVELS - 1) > 127) ? 127 : (LEVELS - 1);

    // Timing in microsecond ticks.
    localparam logic [15:0] LOCKOUT_TICKS = 16'd12500;
    localparam logic [15:0] HOT_WINDOW    = 16'd16767;
    localparam logic [16:0] OFF_DELAY     = 17'd12500;
    localparam logic [15:0] ELAPSED_MAX   = 16'hFFFF;

    typedef enum logic {
        FUNC_TICK = 1'b0,
        FUNC_SET  = 1'b1
    } t_func;

    typedef struct packed {
        t_func      func;
        logic       zc_edge;
        logic [7:0] level_request;
    } t_item;

    typedef struct packed {
        logic       out_level;
        logic       ac_hot;
        logic       crossing_accepted;
        logic [6:0] level_now;
    } t_result;

    // Rise delay in microseconds after the true zero crossing, per level.
    localparam logic [13:0] RISE_ROM [128] = '{
        14'd8333, 14'd7862, 14'd7666, 14'd7515, 14'd7387, 14'd7274, 14'd7171, 14'd7076,
        14'd6987, 14'd6904, 14'd6824, 14'd6749, 14'd6676, 14'd6606, 14'd6538, 14'd6472,
        14'd6408, 14'd6346, 14'd6286, 14'd6226, 14'd6168, 14'd6112, 14'd6056, 14'd6001,
        14'd5947, 14'd5895, 14'd5842, 14'd5791, 14'd5740, 14'd5690, 14'd5641, 14'd5592,
        14'd5544, 14'd5496, 14'd5448, 14'd5401, 14'd5355, 14'd5309, 14'd5263, 14'd5217,
        14'd5172, 14'd5127, 14'd5083, 14'd5039, 14'd4995, 14'd4951, 14'd4907, 14'd4864,
        14'd4821, 14'd4778, 14'd4735, 14'd4692, 14'd4650, 14'd4607, 14'd4565, 14'd4523,
        14'd4481, 14'd4439, 14'd4397, 14'd4355, 14'd4313, 14'd4271, 14'd4229, 14'd4188,
        14'd4146, 14'd4104, 14'd4062, 14'd4020, 14'd3979, 14'd3937, 14'd3895, 14'd3853,
        14'd3811, 14'd3768, 14'd3726, 14'd3684, 14'd3641, 14'd3598, 14'd3556, 14'd3513,
        14'd3469, 14'd3426, 14'd3382, 14'd3339, 14'd3295, 14'd3250, 14'd3206, 14'd3161,
        14'd3116, 14'd3071, 14'd3025, 14'd2979, 14'd2932, 14'd2885, 14'd2838, 14'd2790,
        14'd2741, 14'd2693, 14'd2643, 14'd2593, 14'd2542, 14'd2491, 14'd2439, 14'd2386,
        14'd2332, 14'd2277, 14'd2222, 14'd2165, 14'd2107, 14'd2048, 14'd1987, 14'd1925,
        14'd1861, 14'd1795, 14'd1728, 14'd1658, 14'd1585, 14'd1509, 14'd1430, 14'd1346,
        14'd1257, 14'd1162, 14'd1060, 14'd947,  14'd819,  14'd668,  14'd471,  14'd0
    };

endpackage

// File: hdl/aphf_chan_if.sv
// ============================================================================
// aphf_chan_if: valid/ready channel
// Carries one word of the given payload type from a source to a sink.
// ============================================================================
interface aphf_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/aphf_in_reg.sv
// ============================================================================
// aphf_in_reg: input register
// Captures one item word and holds it until the firing engine takes it.
// ============================================================================
module aphf_in_reg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    aphf_chan_if.sink      i_item,
    output logic           o_valid,
    output aphf_pkg::t_item o_item,
    input  logic           i_take
);
    import aphf_pkg::*;

    logic  r_valid;
    t_item r_item;

    // The register may refill in the same cycle that its word is taken.
    assign i_item.ready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item <= i_item.data;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// File: hdl/aphf_engine.sv
// ============================================================================
// aphf_engine: firing state and result register
// Advances the tick timebase, schedules rise and fall of the switch drive
// and registers one result word per item.
// ============================================================================
module aphf_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    aphf_chan_if.sink       i_cfg,
    input  logic            i_valid,
    input  aphf_pkg::t_item i_item,
    output logic            o_take,
    aphf_chan_if.source     o_result
);
    import aphf_pkg::*;

    logic [14:0] r_shift;
    logic [15:0] r_elapsed, n_elapsed;
    logic [6:0]  r_level, n_level;
    logic        r_on_pend, n_on_pend;
    logic        r_off_pend, n_off_pend;
    logic [15:0] r_on_delay, n_on_delay;
    logic        r_drive, n_drive;
    logic        n_accepted;
    logic        r_out_valid;
    t_result     r_res;

    logic [15:0] elapsed_inc;
    logic [16:0] off_time;

    assign i_cfg.ready = 1'b1;
    assign o_take      = i_valid && (!r_out_valid || o_result.ready);

    assign elapsed_inc = (r_elapsed == ELAPSED_MAX) ? r_elapsed : r_elapsed + 16'd1;
    assign off_time    = {2'b00, r_shift} + OFF_DELAY;

    always_comb begin
        n_elapsed  = r_elapsed;
        n_level    = r_level;
        n_on_pend  = r_on_pend;
        n_off_pend = r_off_pend;
        n_on_delay = r_on_delay;
        n_drive    = r_drive;
        n_accepted = 1'b0;
        if (i_item.func == FUNC_SET) begin
            if (i_item.level_request > 8'(TOP_LEVEL)) begin
                n_level = 7'(TOP_LEVEL);
            end else begin
                n_level = i_item.level_request[6:0];
            end
        end else begin
            n_elapsed = elapsed_inc;
            if (i_item.zc_edge && (elapsed_inc > LOCKOUT_TICKS)) begin
                n_accepted = 1'b1;
                n_elapsed  = '0;
                if (r_level != 7'd0) begin
                    n_on_pend  = 1'b1;
                    n_off_pend = 1'b1;
                    n_on_delay = 16'({1'b0, r_shift} + {2'b00, RISE_ROM[r_level]});
                end else begin
                    n_on_pend  = 1'b0;
                    n_off_pend = 1'b0;
                end
            end
            if (n_on_pend && (n_elapsed >= n_on_delay)) begin
                n_drive   = 1'b1;
                n_on_pend = 1'b0;
            end
            if (n_off_pend && ({1'b0, n_elapsed} >= off_time)) begin
                n_drive    = 1'b0;
                n_off_pend = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift     <= '0;
            r_elapsed   <= '0;
            r_level     <= '0;
            r_on_pend   <= 1'b0;
            r_off_pend  <= 1'b0;
            r_on_delay  <= '0;
            r_drive     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_shift <= i_cfg.data;
            end
            if (o_take) begin
                r_elapsed  <= n_elapsed;
                r_level    <= n_level;
                r_on_pend  <= n_on_pend;
                r_off_pend <= n_off_pend;
                r_on_delay <= n_on_delay;
                r_drive    <= n_drive;
            end
            if (o_take) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res.out_level         <= n_drive;
            r_res.ac_hot            <= (n_elapsed < HOT_WINDOW);
            r_res.crossing_accepted <= n_accepted;
            r_res.level_now         <= n_level;
        end
    end

    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_res;
endmodule

// File: hdl/ac_phase_angle_firing.sv
// ============================================================================
// ac_phase_angle_firing: phase-angle firing of an AC load switch
// Each item is either a one-microsecond tick, which may carry a zero-cross
// edge, or a power-level setting. Every item yields exactly one result word.
// An edge is accepted once more than 12500 ticks have passed since the last
// accepted crossing; with a level above zero the drive then rises after the
// crossing shift plus a table delay and falls after the shift plus 12500.
// Channels: i_item takes item words, o_result gives result words, and i_cfg
// writes the crossing shift in microseconds; it is always ready and should
// only be written while no item is in flight.
// An accepted item is held in the input register until the firing engine
// takes it, and its result word is then registered in the result register,
// from which the receiver takes it. Throughput is one item per cycle while
// the receiver does not stall. When the receiver stalls, the result register
// holds its word and the input register still takes one more item if it is
// empty; after that i_item.ready drops until the result is taken. Reset clears
// both registers, the tick count, the level, the pending events, the drive
// and the crossing shift. The tick count starts at zero, so mains reads as hot
// and edges are locked out after reset.
// ============================================================================
module ac_phase_angle_firing (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aphf_chan_if.sink   i_item,
    aphf_chan_if.sink   i_cfg,
    aphf_chan_if.source o_result
);
    import aphf_pkg::*;

    logic  stage_valid;
    t_item stage_item;
    logic  stage_take;

    // Input register: holds one item word until the firing engine takes it.
    aphf_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .o_valid (stage_valid),
        .o_item  (stage_item),
        .i_take  (stage_take)
    );

    // Firing engine: updates the state once per item and registers its result.
    aphf_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (i_cfg),
        .i_valid  (stage_valid),
        .i_item   (stage_item),
        .o_take   (stage_take),
        .o_result (o_result)
    );
endmodule
